/* hdl/sbfd_pkg.sv */
// Shared types and constants for the servo bus frame deframer.
package sbfd_pkg;

	localparam int STORE_DEPTH_DEF = 16;
	localparam int POS_W           = 4;

	localparam logic [7:0] HEADER_RESET  = 8'h55;
	localparam logic [3:0] MAX_LEN_RESET = 4'd8;
	localparam logic [3:0] MIN_LEN       = 4'd2;
	localparam logic [3:0] CAP_LEN       = 4'd14;
	localparam logic [3:0] LEN_POS       = 4'd2;

	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam logic REG_HEADER  = 1'b0;
	localparam logic REG_MAX_LEN = 1'b1;

	typedef struct packed {
		logic             we;
		logic [POS_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             start;
		logic [POS_W-1:0] last_idx;
	} hunt_evt_t;

endpackage

/* hdl/sbfd_hunt.sv */
// Header hunt, length check and mailbox tracking; issues store writes and drain starts.
module sbfd_hunt #(
	parameter int STORE_DEPTH = sbfd_pkg::STORE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                kind,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          header_byte,
	input  logic [3:0]          max_length,
	output sbfd_pkg::hunt_evt_t evt,
	output logic [7:0]          hdr
);
	import sbfd_pkg::*;

	logic             in_frame_q;
	logic             header_seen_q;
	logic [POS_W-1:0] wpos_q;
	logic [POS_W-1:0] flen_q;
	logic             mbox_full_q;
	logic [7:0]       hdr_q;

	logic             byte_acc;
	logic             at_len;
	logic [3:0]       maxl;
	logic             bad_len;
	logic [POS_W-1:0] flen_eff;
	logic [POS_W:0]   nxt_pos;
	logic [POS_W:0]   total;
	logic             done;

	assign byte_acc = accept && (kind == KIND_BYTE);
	assign at_len   = (wpos_q == LEN_POS);
	assign maxl     = (max_length > CAP_LEN) ? CAP_LEN : max_length;
	assign bad_len  = (rx_byte < {4'd0, MIN_LEN}) || (rx_byte > {4'd0, maxl});
	assign flen_eff = at_len ? rx_byte[POS_W-1:0] : flen_q;
	assign nxt_pos  = {1'b0, wpos_q} + 5'd1;
	assign total    = {1'b0, flen_eff} + 5'd2;
	assign done     = byte_acc && in_frame_q && !(at_len && bad_len) && (nxt_pos == total);

	always_comb begin
		evt          = '0;
		evt.we       = byte_acc && in_frame_q && (int'(wpos_q) < STORE_DEPTH);
		evt.waddr    = wpos_q;
		evt.wdata    = rx_byte;
		evt.start    = done && !mbox_full_q;
		evt.last_idx = flen_eff + 4'd1;
	end

	assign hdr = hdr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			header_seen_q <= 1'b0;
			wpos_q        <= '0;
			flen_q        <= MIN_LEN;
			mbox_full_q   <= 1'b0;
		end else if (accept) begin
			if (kind == KIND_RELEASE) begin
				mbox_full_q <= 1'b0;
			end else if (!in_frame_q) begin
				if (rx_byte == header_byte) begin
					if (header_seen_q) begin
						header_seen_q <= 1'b0;
						in_frame_q    <= 1'b1;
						wpos_q        <= LEN_POS;
					end else begin
						header_seen_q <= 1'b1;
					end
				end else begin
					header_seen_q <= 1'b0;
					wpos_q        <= '0;
				end
			end else if (at_len && bad_len) begin
				flen_q     <= MIN_LEN;
				in_frame_q <= 1'b0;
				wpos_q     <= 4'd3;
			end else begin
				flen_q <= flen_eff;
				wpos_q <= nxt_pos[POS_W-1:0];
				if (done) begin
					in_frame_q  <= 1'b0;
					mbox_full_q <= 1'b1;
				end
			end
		end
	end

	// Both header slots carry the same byte; kept here instead of in the store.
	always_ff @(posedge clk) begin
		if (byte_acc && !in_frame_q && header_seen_q && (rx_byte == header_byte)) begin
			hdr_q <= rx_byte;
		end
	end

endmodule

/* hdl/servo_bus_frame_deframer_top.sv */
// Deframer top: config registers, frame store memory and the drain sequencer.
// A frame-completing byte starts a drain unless the mailbox is still full.
// The completing byte moves the sequencer to ST_DRAIN; each byte is then read into the output registers,
// one byte per cycle unless the output stalls. The input is held off for as long as a frame drains.
// Reset restores the config defaults and clears the hunt and drain control state; the store is not cleared.
module servo_bus_frame_deframer_top #(
	parameter int STORE_DEPTH = sbfd_pkg::STORE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] byte_index,
	output logic [7:0] frame_byte,
	output logic       last_byte
);
	import sbfd_pkg::*;

	localparam int ADDR_W = $clog2(STORE_DEPTH);

	typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

	state_t           state_q;
	logic [7:0]       header_byte_q;
	logic [3:0]       max_length_q;
	logic [POS_W-1:0] k_q;
	logic [POS_W-1:0] last_idx_q;
	logic             out_valid_q;
	logic [POS_W-1:0] out_idx_q;
	logic             out_last_q;
	logic [7:0]       rd_data_q;
	logic [7:0]       store_mem [STORE_DEPTH];

	hunt_evt_t        hunt_evt;
	logic [7:0]       hdr;
	logic             in_acc;
	logic             advance;
	logic             load;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign advance  = !out_valid_q || out_ready;
	assign load     = (state_q == ST_DRAIN) && advance;

	sbfd_hunt #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_hunt (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_acc),
		.kind        (kind),
		.rx_byte     (rx_byte),
		.header_byte (header_byte_q),
		.max_length  (max_length_q),
		.evt         (hunt_evt),
		.hdr         (hdr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_byte_q <= HEADER_RESET;
			max_length_q  <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER:  header_byte_q <= cfg_data;
				REG_MAX_LEN: max_length_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			last_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (hunt_evt.start) begin
						state_q    <= ST_DRAIN;
						k_q        <= '0;
						last_idx_q <= hunt_evt.last_idx;
					end
				end
				ST_DRAIN: begin
					if (advance) begin
						k_q <= k_q + 4'd1;
						if (k_q == last_idx_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_idx_q  <= k_q;
			out_last_q <= (k_q == last_idx_q);
		end
	end

	always_ff @(posedge clk) begin
		if (hunt_evt.we) begin
			store_mem[ADDR_W'(hunt_evt.waddr)] <= hunt_evt.wdata;
		end
		if (load) begin
			rd_data_q <= store_mem[ADDR_W'(k_q)];
		end
	end

	assign out_valid  = out_valid_q;
	assign byte_index = out_idx_q;
	assign last_byte  = out_last_q;

	always_comb begin
		if (out_idx_q < LEN_POS) begin
			frame_byte = hdr;
		end else if (int'(out_idx_q) < STORE_DEPTH) begin
			frame_byte = rd_data_q;
		end else begin
			frame_byte = 8'd0;
		end
	end

`ifndef SYNTHESIS
	a_drain_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_byte |=>
			out_valid && (byte_index == $past(byte_index) + 4'd1))
		else $error("drain skipped or stalled mid-frame");

	a_no_input_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !in_ready)
		else $error("input taken while draining");

	a_start_sane: assert property (@(posedge clk) disable iff (!arst_n)
		hunt_evt.start |-> (state_q == ST_IDLE) && (hunt_evt.last_idx >= 4'd3))
		else $error("drain start with bad state or length");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the servo bus frame deframer: frame prediction and beat checks.
`timescale 1ns / 1ps

module tb;
	import sbfd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
	} rx_item_t;

	typedef struct packed {
		logic [3:0] idx;
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       cfg_we     = 1'b0;
	logic       cfg_index  = 1'b0;
	logic [7:0] cfg_data   = 8'h00;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic       kind       = 1'b0;
	logic [7:0] rx_byte    = 8'h00;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic [3:0] byte_index;
	logic [7:0] frame_byte;
	logic       last_byte;

	servo_bus_frame_deframer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.byte_index(byte_index),
		.frame_byte(frame_byte),
		.last_byte (last_byte)
	);

	always #2 clk = ~clk;

	// stimulus and expected frame beats
	rx_item_t    pend_q[$];
	frame_beat_t beat_q[$];
	rx_item_t    nxt_item;
	frame_beat_t want;

	// deframer shadow state
	logic [7:0] cfg_header  = HEADER_RESET;
	logic [3:0] cfg_max_len = MAX_LEN_RESET;
	logic       p_in_frame  = 1'b0;
	logic       p_hdr_seen  = 1'b0;
	logic [3:0] p_wr_pos    = 4'd0;
	int         p_frm_len   = 2;
	logic [7:0] p_store[16];
	logic       p_mbox_full = 1'b0;

	bit in_taken   = 1'b0;
	bit idle_en    = 1'b1;
	int send_gap   = 0;
	int stall_left = 0;
	int hold_left  = 0;
	int hold_req   = 0;
	int hold_done  = 0;
	int quiet      = 0;
	int err_cnt    = 0;
	int n_in       = 0;
	int n_beats    = 0;
	int n_frames   = 0;
	int n_settings = 0;

	function automatic int pick_gap(input bit enable);
		int r;
		r = $urandom_range(0, 99);
		if (!enable || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] exp_val);
		err_cnt++;
		$display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, exp_val);
	endtask

	task automatic deframe_step(input logic k, input logic [7:0] b);
		int pos, total, lim, i;
		frame_beat_t beat;
		if (k == KIND_RELEASE) begin
			p_mbox_full = 1'b0;
			return;
		end
		if (!p_in_frame) begin
			if (b == cfg_header) begin
				if (p_hdr_seen) begin
					p_hdr_seen = 1'b0;
					p_in_frame = 1'b1;
					p_store[0] = b;
					p_wr_pos   = 4'd1;
				end else begin
					p_hdr_seen = 1'b1;
				end
			end else begin
				p_hdr_seen = 1'b0;
				p_wr_pos   = 4'd0;
			end
			if (!p_in_frame)
				return;
		end
		pos = int'(p_wr_pos);
		p_store[pos] = b;
		if (pos == int'(LEN_POS)) begin
			lim = int'((cfg_max_len > CAP_LEN) ? CAP_LEN : cfg_max_len);
			if (int'(b) < int'(MIN_LEN) || int'(b) > lim) begin
				p_frm_len  = 2;
				p_in_frame = 1'b0;
				p_wr_pos   = 4'd3;
				return;
			end
			p_frm_len = int'(b);
		end
		pos++;
		p_wr_pos = pos[3:0];
		total = p_frm_len + 2;
		if (pos == total) begin
			p_in_frame = 1'b0;
			if (!p_mbox_full) begin
				p_mbox_full = 1'b1;
				for (i = 0; i < total && i < 16; i++) begin
					beat.idx  = i[3:0];
					beat.data = p_store[i];
					beat.last = (i + 1 == total);
					beat_q.push_back(beat);
				end
			end
		end
	endtask

	// sender: one item in flight, new item or gap chosen after each transfer
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pend_q.size() > 0) begin
				nxt_item = pend_q.pop_front();
				in_valid <= 1'b1;
				kind     <= nxt_item.kind;
				rx_byte  <= nxt_item.data;
				send_gap = pick_gap(idle_en);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_done != hold_req) begin
			hold_done++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			stall_left = pick_gap(idle_en);
		end
	end

	// transfer sampling, prediction, beat checks and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				n_in++;
				deframe_step(kind, rx_byte);
			end
			if (out_valid && out_ready) begin
				n_beats++;
				if (last_byte === 1'b1)
					n_frames++;
				if (beat_q.size() == 0) begin
					report_mismatch("beat with no frame pending", frame_byte, 8'h00);
				end else begin
					want = beat_q.pop_front();
					if (byte_index !== want.idx)
						report_mismatch("byte_index", {4'd0, byte_index}, {4'd0, want.idx});
					if (frame_byte !== want.data)
						report_mismatch("frame_byte", frame_byte, want.data);
					if (last_byte !== want.last)
						report_mismatch("last_byte", {7'd0, last_byte}, {7'd0, want.last});
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic push_item(input logic k, input logic [7:0] b);
		rx_item_t it;
		it.kind = k;
		it.data = b;
		pend_q.push_back(it);
	endtask

	task automatic push_frame(input int len);
		int i;
		push_item(KIND_BYTE, cfg_header);
		push_item(KIND_BYTE, cfg_header);
		push_item(KIND_BYTE, len[7:0]);
		for (i = 0; i < len - 1; i++)
			push_item(KIND_BYTE, 8'($urandom_range(0, 255)));
	endtask

	task automatic settle();
		while (pend_q.size() != 0 || in_valid || beat_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		if (idx == REG_HEADER)
			cfg_header = val;
		else
			cfg_max_len = val[3:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_random(input int n_items);
		int cnt, r, lim, len;
		logic [7:0] b;
		cnt = 0;
		lim = int'((cfg_max_len > CAP_LEN) ? CAP_LEN : cfg_max_len);
		while (cnt < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				push_item(KIND_RELEASE, 8'($urandom_range(0, 255)));
				cnt++;
			end else if (r < 18) begin
				push_item(KIND_BYTE, 8'($urandom_range(0, 255)));
				cnt++;
			end else if (r < 26) begin
				push_item(KIND_BYTE, cfg_header);
				do
					b = 8'($urandom_range(0, 255));
				while (b == cfg_header);
				push_item(KIND_BYTE, b);
				cnt += 2;
			end else if (r < 36 || lim < int'(MIN_LEN)) begin
				push_item(KIND_BYTE, cfg_header);
				push_item(KIND_BYTE, cfg_header);
				case ($urandom_range(0, 2))
					0: b = 8'($urandom_range(0, 1));
					1: b = 8'(lim + 1);
					default: b = 8'($urandom_range(lim + 1, 255));
				endcase
				push_item(KIND_BYTE, b);
				cnt += 3;
			end else begin
				len = $urandom_range(int'(MIN_LEN), lim);
				push_frame(len);
				cnt += len + 2;
				if ($urandom_range(0, 9) < 7) begin
					push_item(KIND_RELEASE, 8'($urandom_range(0, 255)));
					cnt++;
				end
			end
		end
	endtask

	initial begin
		logic [7:0] h;
		logic [7:0] m;
		int ph;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: broken header, longest frame, full-mailbox drop, release, bad lengths
		push_item(KIND_BYTE, 8'h55);
		push_item(KIND_BYTE, 8'h12);
		push_item(KIND_BYTE, 8'h55);
		push_item(KIND_BYTE, 8'h55);
		push_item(KIND_BYTE, 8'h08);
		push_item(KIND_BYTE, 8'h00);
		push_item(KIND_BYTE, 8'hFF);
		push_item(KIND_BYTE, 8'h55);
		push_item(KIND_BYTE, 8'h55);
		push_item(KIND_BYTE, 8'hA5);
		push_item(KIND_BYTE, 8'h5A);
		push_item(KIND_BYTE, 8'h01);
		push_item(KIND_BYTE, 8'h55);
		push_item(KIND_BYTE, 8'h55);
		push_item(KIND_BYTE, 8'h02);
		push_item(KIND_BYTE, 8'h3C);
		push_item(KIND_RELEASE, 8'hFF);
		push_item(KIND_BYTE, 8'h55);
		push_item(KIND_BYTE, 8'h55);
		push_item(KIND_BYTE, 8'h01);
		push_item(KIND_BYTE, 8'h55);
		push_item(KIND_BYTE, 8'h55);
		push_item(KIND_BYTE, 8'h09);
		push_item(KIND_RELEASE, 8'h00);
		settle();
		n_settings = 1;

		for (ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin h = 8'h00; m = 8'd14; end
				1: begin h = 8'hFF; m = 8'd2;  end
				2: begin h = 8'hA5; m = 8'd15; end
				3: begin h = 8'h5A; m = 8'd1;  end
				4: begin h = 8'h3C; m = 8'd0;  end
				5: begin h = 8'hC3; m = 8'd8;  end
				default: begin
					h = 8'($urandom_range(0, 255));
					m = 8'($urandom_range(2, 14));
				end
			endcase
			write_cfg(REG_HEADER, h);
			write_cfg(REG_MAX_LEN, m);
			n_settings++;
			idle_en = (ph != 2 && ph != 7);
			push_item(KIND_RELEASE, 8'($urandom_range(0, 255)));
			if (ph == 0)
				hold_req++;
			run_random((m < 8'd2) ? 20 : 40);
			settle();
		end

		$display("covered %0d input transfers over %0d register settings", n_in, n_settings);
		$display("checked %0d frame beats in %0d emitted frames", n_beats, n_frames);
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
